// ----- sv/rrt_pkg.sv -----
// Package for the 3D tree growth block: payload structs, status and command codes.
// Used by rrt_tree_extend_top and rrt_steer; depends on nothing.
`timescale 1ns / 1ps
package rrt_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned IdxW = 12;

	typedef enum logic [1:0] {
		CMD_EXTEND  = 2'd0,
		CMD_READ    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_GOAL     = 3'd1,
		ST_CLOSE    = 3'd2,
		ST_LIMIT    = 3'd3,
		ST_READ     = 3'd4,
		ST_FINISHED = 3'd5,
		ST_BAD_IDX  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_MIN_DIST  = 3'd0,
		REG_MAX_DIST  = 3'd1,
		REG_START     = 3'd2,
		REG_GOAL      = 3'd3,
		REG_ITER_LIM  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [IdxW-1:0] node_index;
		logic [7:0]      sample_z;
		logic [7:0]      sample_y;
		logic [7:0]      sample_x;
		logic [1:0]      command;
	} req_t;

	typedef struct packed {
		logic [CoordW-1:0] point_z;
		logic [CoordW-1:0] point_y;
		logic [CoordW-1:0] point_x;
		logic [IdxW-1:0]   parent_index;
		logic [IdxW-1:0]   result_index;
		logic [2:0]        status;
	} rsp_t;

	// Control between the top level and the steering unit.
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} steer_ctl_t;

endpackage

// ----- sv/rrt_steer.sv -----
// Steering unit: bit-serial integer square root, then three bit-serial divides.
// Depends on rrt_pkg.
`timescale 1ns / 1ps
module rrt_steer import rrt_pkg::*; #(
	parameter int unsigned CW = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2*CW+1:0]  dsq,
	input  logic [CW-1:0]    radius,
	input  logic [CW-1:0]    dx,
	input  logic [CW-1:0]    dy,
	input  logic [CW-1:0]    dz,
	output steer_ctl_t       ctl,
	output logic [CW-1:0]    ox,
	output logic [CW-1:0]    oy,
	output logic [CW-1:0]    oz
);

	localparam int unsigned DW = 2*CW + 2;
	localparam int unsigned RW = CW + 1;
	localparam int unsigned NW = 2*CW;
	localparam int unsigned CNTW = $clog2(NW + 1);

	typedef enum logic [1:0] {IDLE, SQRT, DIV, DONE} st_t;

	st_t st_q;
	logic [CNTW-1:0] cnt_q;
	logic [1:0] axis_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] val_q;
	logic [RW-1:0] root_q;
	logic [NW-1:0] num_q;
	logic [RW:0]   drem_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] d_q [3];

	// Restoring square root, one result bit per cycle.
	logic [DW-1:0] sq_rem_sh;
	logic [DW-1:0] sq_trial;
	always_comb begin
		sq_rem_sh = {rem_q[DW-3:0], val_q[DW-1 -: 2]};
		sq_trial = {{(DW-RW-2){1'b0}}, root_q, 2'b01};
	end

	// Restoring divide of |d|*radius by the root, one quotient bit per cycle.
	logic [RW:0] dv_sh;
	always_comb dv_sh = {drem_q[RW-1:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			cnt_q <= '0;
			axis_q <= '0;
		end else begin
			case (st_q)
				IDLE: begin
					if (start) begin
						st_q <= SQRT;
						cnt_q <= CNTW'(DW/2);
						rem_q <= '0;
						val_q <= dsq;
						root_q <= '0;
						d_q[0] <= dx;
						d_q[1] <= dy;
						d_q[2] <= dz;
						axis_q <= '0;
					end
				end
				SQRT: begin
					val_q <= val_q << 2;
					if (sq_rem_sh >= sq_trial) begin
						rem_q <= sq_rem_sh - sq_trial;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q <= sq_rem_sh;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						st_q <= DIV;
						cnt_q <= CNTW'(NW);
						num_q <= d_q[0] * radius;
						drem_q <= '0;
					end
				end
				DIV: begin
					num_q <= num_q << 1;
					if (dv_sh >= {1'b0, root_q}) begin
						drem_q <= dv_sh - {1'b0, root_q};
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						drem_q <= dv_sh;
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						cnt_q <= CNTW'(NW);
						drem_q <= '0;
						axis_q <= axis_q + 1'b1;
						if (axis_q == 2'd2) st_q <= DONE;
						else num_q <= d_q[axis_q + 1'b1] * radius;
					end
				end
				DONE: st_q <= IDLE;
				default: st_q <= IDLE;
			endcase
		end
	end

	// Capture each quotient when its last bit lands.
	logic [NW-1:0] quo_fin;
	always_comb quo_fin = (dv_sh >= {1'b0, root_q}) ? {quo_q[NW-2:0], 1'b1} :
		{quo_q[NW-2:0], 1'b0};
	always_ff @(posedge clk) begin
		if (st_q == DIV && cnt_q == CNTW'(1)) begin
			case (axis_q)
				2'd0: ox <= quo_fin[CW-1:0];
				2'd1: oy <= quo_fin[CW-1:0];
				default: oz <= quo_fin[CW-1:0];
			endcase
		end
	end

	always_comb begin
		ctl.start = start;
		ctl.busy = (st_q != IDLE);
		ctl.done = (st_q == DONE);
	end

`ifndef SYNTHESIS
	a_root_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == DIV) |-> (root_q != '0)) else $error("steer: zero root in divide");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != IDLE) |-> !start) else $error("steer: start while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == DONE) |=> (st_q == IDLE)) else $error("steer: done held");
`endif

endmodule

// ----- sv/rrt_tree_extend_top.sv -----
// Top level of the 3D tree growth block: APB registers, node memory, nearest scan.
// Depends on rrt_pkg and rrt_steer.
//
//  channel | direction | handshake
//  req     | in        | req_valid / req_ready
//  rsp     | out       | rsp_valid / rsp_ready
//  apb     | in/out    | psel, penable, pwrite, pready
//
// An extend request makes one memory read per node in the scan, drains the scan pipeline,
// reads the nearest node, sums the squared goal distance one axis at a time and writes
// the new node. A steered extend also runs the serial square root and three divides; a
// rejected sample answers before the goal sums. Restarts give no response. Reset cuts the
// tree back to the start node at once; no clearing pass. A stalled response holds the
// block; no new request is taken.
`timescale 1ns / 1ps
module rrt_tree_extend_top import rrt_pkg::*; #(
	parameter int unsigned NODE_CAPACITY = 4096,
	parameter int unsigned FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned AW = $clog2(NODE_CAPACITY);
	localparam int unsigned TW = AW + 1;
	localparam int unsigned CW = 8 + FRACTION_BITS;
	localparam int unsigned DW = 2*CW + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_RDWAIT, S_RDOUT, S_SCAN, S_SCANEND, S_NEAR, S_NEARW, S_DIST,
		S_STEER, S_GOAL, S_WRITE, S_OUT
	} state_t;

	// Registers.
	logic [7:0]  min_q, max_q;
	logic [23:0] start_q, goal_q;
	logic [11:0] lim_q;
	logic apb_wr;
	always_comb begin
		pready = 1'b1;
		apb_wr = psel && penable && pwrite;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 8'd5;
			max_q <= 8'd10;
			start_q <= '0;
			goal_q <= 24'h323232;
			lim_q <= 12'd4095;
		end else if (apb_wr) begin
			case (paddr[4:2])
				REG_MIN_DIST: min_q <= pwdata[7:0];
				REG_MAX_DIST: max_q <= pwdata[7:0];
				REG_START:    start_q <= pwdata[23:0];
				REG_GOAL:     goal_q <= pwdata[23:0];
				REG_ITER_LIM: lim_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[4:2])
			REG_MIN_DIST: prdata = {24'd0, min_q};
			REG_MAX_DIST: prdata = {24'd0, max_q};
			REG_START:    prdata = {8'd0, start_q};
			REG_GOAL:     prdata = {8'd0, goal_q};
			REG_ITER_LIM: prdata = {20'd0, lim_q};
			default:      prdata = '0;
		endcase
	end

	// Node memory: x, y, z and parent in one word.
	localparam int unsigned MW = 3*CW + AW;
	logic [MW-1:0] mem [NODE_CAPACITY];
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic [MW-1:0] rd_data;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

	function automatic logic [CW-1:0] axis_of(input logic [23:0] p, input int a);
		axis_of = {p[8*a +: 8], {FRACTION_BITS{1'b0}}};
	endfunction

	function automatic logic [CW-1:0] adiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		adiff = (a >= b) ? a - b : b - a;
	endfunction

	state_t st_q;
	req_t req_q;
	logic [TW-1:0] total_q;
	logic goal_found_q, limit_hit_q;
	logic [TW-1:0] scan_q;
	logic [TW-1:0] scan_s1;
	logic scan_v_s1;
	logic [DW-1:0] dist_s2;
	logic [TW-1:0] idx_s2;
	logic v_s2;
	logic [DW-1:0] best_d_q;
	logic [AW-1:0] best_q;
	logic [CW-1:0] n_q [3];
	logic [CW-1:0] p_q [3];
	logic [CW-1:0] d_q [3];
	logic [CW-1:0] s [3];
	logic [2:0] sgn_q;
	logic [DW-1:0] sq_q;
	logic [1:0] sq_ax_q;
	logic [CW-1:0] mul_a;
	logic [DW-1:0] mul_p;
	rsp_t rsp_q;
	logic rsp_v_q;

	always_comb begin
		s[0] = {req_q.sample_x, {FRACTION_BITS{1'b0}}};
		s[1] = {req_q.sample_y, {FRACTION_BITS{1'b0}}};
		s[2] = {req_q.sample_z, {FRACTION_BITS{1'b0}}};
	end

	// Scan pipeline: address, read, distance; node 0 comes from the register.
	logic [CW-1:0] nd [3];
	logic [DW-1:0] nd_dist;
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nd[a] = (scan_s1 == '0) ? axis_of(start_q, a) : rd_data[a*CW +: CW];
		end
		nd_dist = DW'(adiff(nd[0], s[0]) * adiff(nd[0], s[0]))
			+ DW'(adiff(nd[1], s[1]) * adiff(nd[1], s[1]))
			+ DW'(adiff(nd[2], s[2]) * adiff(nd[2], s[2]));
	end

	// Steering unit.
	steer_ctl_t sctl;
	logic steer_go;
	logic [CW+7:0] so [3];
	logic [CW+7:0] sd [3];
	always_comb for (int a = 0; a < 3; a++) sd[a] = (CW+8)'(d_q[a]);
	rrt_steer #(.CW(CW + 8)) u_steer (
		.clk(clk), .arst_n(arst_n), .start(steer_go),
		.dsq((2*(CW+8)+2)'(best_d_q)),
		.radius((CW+8)'({max_q, {FRACTION_BITS{1'b0}}})),
		.dx(sd[0]), .dy(sd[1]), .dz(sd[2]), .ctl(sctl),
		.ox(so[0]), .oy(so[1]), .oz(so[2])
	);

	logic [DW-1:0] rmin_sq, rmax_sq, rgoal_sq;
	logic [CW:0] rg;
	always_comb begin
		rmin_sq = DW'({min_q, {FRACTION_BITS{1'b0}}}) * DW'({min_q, {FRACTION_BITS{1'b0}}});
		rmax_sq = DW'({max_q, {FRACTION_BITS{1'b0}}}) * DW'({max_q, {FRACTION_BITS{1'b0}}});
		rg = {({1'b0, min_q} + 9'd1), {FRACTION_BITS{1'b0}}};
		rgoal_sq = DW'(rg) * DW'(rg);
		mul_a = adiff(p_q[sq_ax_q], axis_of(goal_q, int'(sq_ax_q)));
		mul_p = DW'(mul_a) * DW'(mul_a);
	end

	logic fin;
	always_comb fin = goal_found_q || limit_hit_q || (total_q >= TW'(NODE_CAPACITY));

	always_comb begin
		req_ready = (st_q == S_IDLE) && !rsp_v_q;
		rsp_valid = rsp_v_q;
		rsp = rsp_q;
		// The differences are registered in S_DIST, so the unit starts once in S_STEER.
		steer_go = (st_q == S_STEER) && !sctl.busy;
		rd_en = 1'b1;
		rd_addr = scan_q[AW-1:0];
		if (st_q == S_IDLE) rd_addr = AW'(req.node_index);
		else if (st_q == S_RDWAIT) rd_addr = AW'(req_q.node_index);
		else if (st_q == S_NEAR) rd_addr = best_q;
		wr_en = (st_q == S_WRITE);
		wr_addr = total_q[AW-1:0];
		wr_data = {best_q, p_q[2], p_q[1], p_q[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			total_q <= TW'(1);
			goal_found_q <= 1'b0;
			limit_hit_q <= 1'b0;
			rsp_v_q <= 1'b0;
			scan_v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rsp_v_q && rsp_ready) rsp_v_q <= 1'b0;
			scan_v_s1 <= (st_q == S_SCAN);
			v_s2 <= scan_v_s1;
			case (st_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						req_q <= req;
						case (cmd_t'(req.command))
							CMD_RESTART: begin
								total_q <= TW'(1);
								goal_found_q <= 1'b0;
								limit_hit_q <= 1'b0;
							end
							CMD_READ: begin
								rsp_q <= '0;
								st_q <= S_RDWAIT;
							end
							CMD_EXTEND: begin
								if (fin) begin
									rsp_q <= '{status: ST_FINISHED, default: '0};
									rsp_v_q <= 1'b1;
								end else begin
									rsp_q <= '0;
									scan_q <= '0;
									st_q <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_RDWAIT: st_q <= S_RDOUT;
				S_RDOUT: begin
					if (32'(req_q.node_index) >= 32'(total_q)) begin
						rsp_q.status <= ST_BAD_IDX;
					end else begin
						rsp_q.status <= ST_READ;
						rsp_q.result_index <= req_q.node_index;
						if (req_q.node_index == '0) begin
							rsp_q.point_x <= CoordW'(axis_of(start_q, 0));
							rsp_q.point_y <= CoordW'(axis_of(start_q, 1));
							rsp_q.point_z <= CoordW'(axis_of(start_q, 2));
						end else begin
							rsp_q.parent_index <= IdxW'(rd_data[3*CW +: AW]);
							rsp_q.point_x <= CoordW'(rd_data[0 +: CW]);
							rsp_q.point_y <= CoordW'(rd_data[CW +: CW]);
							rsp_q.point_z <= CoordW'(rd_data[2*CW +: CW]);
						end
					end
					rsp_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				S_SCAN: begin
					scan_s1 <= scan_q;
					scan_q <= scan_q + 1'b1;
					if (scan_q + 1'b1 == total_q) st_q <= S_SCANEND;
				end
				S_SCANEND: begin
					// Drain the scan pipeline.
					if (!scan_v_s1 && !v_s2) st_q <= S_NEAR;
				end
				S_NEAR: st_q <= S_NEARW;
				S_NEARW: begin
					for (int a = 0; a < 3; a++) begin
						n_q[a] <= (best_q == '0) ? axis_of(start_q, a) : rd_data[a*CW +: CW];
					end
					st_q <= S_DIST;
				end
				S_DIST: begin
					for (int a = 0; a < 3; a++) begin
						d_q[a] <= adiff(s[a], n_q[a]);
						sgn_q[a] <= s[a] >= n_q[a];
						p_q[a] <= s[a];
					end
					if (best_d_q < rmin_sq) begin
						rsp_q.status <= ST_CLOSE;
						rsp_v_q <= 1'b1;
						st_q <= S_IDLE;
					end else if (best_d_q > rmax_sq) begin
						st_q <= S_STEER;
					end else begin
						st_q <= S_GOAL;
						sq_ax_q <= '0;
						sq_q <= '0;
					end
				end
				S_STEER: begin
					if (sctl.done) begin
						for (int a = 0; a < 3; a++) begin
							p_q[a] <= sgn_q[a] ? n_q[a] + so[a][CW-1:0]
								: n_q[a] - so[a][CW-1:0];
						end
						st_q <= S_GOAL;
						sq_ax_q <= '0;
						sq_q <= '0;
					end
				end
				S_GOAL: begin
					// One axis squared per cycle.
					if (sq_ax_q == 2'd3) begin
						if (sq_q <= rgoal_sq) begin
							for (int a = 0; a < 3; a++) p_q[a] <= axis_of(goal_q, a);
							goal_found_q <= 1'b1;
							rsp_q.status <= ST_GOAL;
						end else begin
							rsp_q.status <= ST_ADDED;
						end
						st_q <= S_WRITE;
					end else begin
						sq_q <= sq_q + mul_p;
						sq_ax_q <= sq_ax_q + 1'b1;
					end
				end
				S_WRITE: begin
					total_q <= total_q + 1'b1;
					if (!goal_found_q && ((total_q >= TW'(lim_q))
						|| (total_q + 1'b1 >= TW'(NODE_CAPACITY)))) begin
						limit_hit_q <= 1'b1;
						rsp_q.status <= ST_LIMIT;
					end
					rsp_q.result_index <= IdxW'(total_q);
					rsp_q.parent_index <= IdxW'(best_q);
					rsp_q.point_x <= CoordW'(p_q[0]);
					rsp_q.point_y <= CoordW'(p_q[1]);
					rsp_q.point_z <= CoordW'(p_q[2]);
					st_q <= S_OUT;
				end
				S_OUT: begin
					rsp_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			if (scan_v_s1) begin
				dist_s2 <= nd_dist;
				idx_s2 <= scan_s1;
			end
			if (v_s2 && (idx_s2 == '0 || dist_s2 < best_d_q)) begin
				best_d_q <= dist_s2;
				best_q <= idx_s2[AW-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q >= TW'(1)) && (total_q <= TW'(NODE_CAPACITY)))
		else $error("top: node count out of range");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (total_q < TW'(NODE_CAPACITY))) else $error("top: write past capacity");
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_q |-> (st_q == S_IDLE)) else $error("top: response while busy");
	a_goal_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(goal_found_q && st_q == S_IDLE) |=> !wr_en) else $error("top: growth after goal");
`endif

endmodule
